// ----- src/sblm_pkg.sv -----
`timescale 1ns / 1ps
package sblm_pkg;

	typedef struct packed {
		logic signed [9:0] bin_level;
		logic              frame_end;
	} bin_t;

	typedef struct packed {
		logic [3:0]  band_number;
		logic [7:0]  first_led;
		logic [7:0]  lit_count;
		logic [23:0] rgb_colour;
		logic [31:0] brightness;
	} band_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SQUARE,
		ST_DIV_B,
		ST_WAIT_B,
		ST_DIV_S,
		ST_WAIT_S,
		ST_DIV_L,
		ST_WAIT_L,
		ST_DONE
	} state_t;

	localparam logic [31:0] AVG_RESET = 32'd100;
	localparam logic [31:0] AVG_FLOOR = 32'd10;
	localparam logic [9:0]  COUNTER_TOP = 10'd1023;
	localparam int          DIV_STEPS = 32;

	localparam logic [23:0] BAND_COLOURS [12] = '{
		24'hff0000, 24'hff8000, 24'hffff00, 24'h80ff00,
		24'h00ff00, 24'h00ff80, 24'h00ffff, 24'h0080ff,
		24'h0000ff, 24'h8000ff, 24'hff00ff, 24'hff0080
	};

endpackage

// ----- src/sblm_div.sv -----
`timescale 1ns / 1ps
module sblm_div import sblm_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] dividend,
	input  logic [31:0] divisor,
	output div_stat_t   stat,
	output logic [31:0] quotient
);

	logic [5:0]  cnt_q;
	logic        done_q;
	logic [31:0] rem_q;
	logic [31:0] quo_q;
	logic [31:0] divisor_q;
	logic [32:0] shifted;
	logic [32:0] diff;

	assign shifted = {rem_q, quo_q[31]};
	assign diff    = shifted - {1'b0, divisor_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q  <= 6'(DIV_STEPS);
			done_q <= 1'b0;
		end else begin
			done_q <= (cnt_q == 6'd1);
			if (cnt_q != '0) begin
				cnt_q <= cnt_q - 6'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q     <= '0;
			quo_q     <= dividend;
			divisor_q <= divisor;
		end else if (cnt_q != '0) begin
			if (!diff[32]) begin
				rem_q <= diff[31:0];
				quo_q <= {quo_q[30:0], 1'b1};
			end else begin
				rem_q <= shifted[31:0];
				quo_q <= {quo_q[30:0], 1'b0};
			end
		end
	end

	assign stat.busy = (cnt_q != '0);
	assign stat.done = done_q;
	assign quotient  = quo_q;

endmodule

// ----- src/spectrum_band_led_meter_core.sv -----
`timescale 1ns / 1ps
// Spectrum band LED meter: takes one dB bin per transfer and emits one LED segment per
// closed band. A bin that closes no band is taken and the block stays ready for the next
// bin; a bin that closes a band holds off further bins through the squaring, three passes
// through the shared 32-step restoring divider and the result load, and longer if the
// previous segment has not yet been taken.
module spectrum_band_led_meter_core import sblm_pkg::*; #(
	parameter int BINS_PER_FRAME = 512,
	parameter int START_BIN      = 1,
	parameter int END_BIN        = 232,
	parameter int LED_COUNT      = 60,
	parameter int BAND_COUNT     = 12
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  bin_valid,
	output logic  bin_ready,
	input  bin_t  bin,
	output logic  band_valid,
	input  logic  band_ready,
	output band_t band
);

	localparam int SPAN = (END_BIN > START_BIN) ? (END_BIN - START_BIN) : 0;

	state_t      state_q, state_d;
	logic [9:0]  bin_counter_q;
	logic [31:0] band_total_q;
	logic [31:0] frame_max_q;
	logic [31:0] avg_q;
	logic        pend_last_q;
	logic        band_valid_q;
	band_t       band_q;

	logic [31:0] work_total_q;
	logic [31:0] p_q;
	logic [31:0] bright_q;
	logic [31:0] s_q;
	logic [7:0]  lit_q;
	logic [3:0]  found_q;
	logic [7:0]  first_q;

	logic [9:0]  rel;
	logic        in_range;
	logic [BAND_COUNT-1:0] match;
	logic [BAND_COUNT-1:0] ends;
	logic [7:0]  band_first [BAND_COUNT];
	logic [3:0]  found;
	logic [7:0]  first;
	logic        close;
	logic [31:0] total_new;
	logic        take;
	logic        out_free;
	logic [32:0] avg_sum;
	logic [31:0] avg_new;
	logic [31:0] p_inc;
	logic [31:0] p_led;

	logic        div_start;
	logic [31:0] div_dividend;
	logic [31:0] div_divisor;
	div_stat_t   div_stat;
	logic [31:0] div_quo;

	sblm_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.stat     (div_stat),
		.quotient (div_quo)
	);

	assign rel      = bin_counter_q - 10'(START_BIN);
	assign in_range = ({1'b0, bin_counter_q} < 11'(BINS_PER_FRAME)) &&
		(bin_counter_q >= 10'(START_BIN)) && (rel < 10'(SPAN));

	for (genvar g = 0; g < BAND_COUNT; g++) begin : g_band
		localparam int LO  = (SPAN * g) / BAND_COUNT;
		localparam int HI  = (SPAN * (g + 1)) / BAND_COUNT;
		localparam int FST = (g * LED_COUNT) / BAND_COUNT;
		assign match[g]      = (rel >= 10'(LO)) && (rel < 10'(HI));
		assign ends[g]       = match[g] && ((rel + 10'd1) == 10'(HI));
		assign band_first[g] = 8'(FST);
	end

	always_comb begin
		found = '0;
		first = '0;
		for (int b = 0; b < BAND_COUNT; b++) begin
			if (match[b]) begin
				found = 4'(b);
				first = band_first[b];
			end
		end
	end

	assign close     = in_range && ((|ends) || bin.frame_end);
	assign total_new = band_total_q +
		((bin.bin_level > 10'sd1) ? {22'd0, bin.bin_level} : 32'd0);
	assign take      = bin_valid && bin_ready;
	assign out_free  = !band_valid_q || band_ready;
	assign avg_sum   = {1'b0, avg_q} + {1'b0, frame_max_q};
	assign avg_new   = (avg_sum[32:1] < AVG_FLOOR) ? AVG_FLOOR : avg_sum[32:1];
	assign p_inc     = p_q + 32'd1;
	assign p_led     = p_q * 32'(LED_COUNT);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:   if (take && close) state_d = ST_SQUARE;
			ST_SQUARE: state_d = ST_DIV_B;
			ST_DIV_B:  state_d = ST_WAIT_B;
			ST_WAIT_B: if (div_stat.done) state_d = ST_DIV_S;
			ST_DIV_S:  state_d = ST_WAIT_S;
			ST_WAIT_S: if (div_stat.done) state_d = ST_DIV_L;
			ST_DIV_L:  state_d = ST_WAIT_L;
			ST_WAIT_L: if (div_stat.done) state_d = ST_DONE;
			ST_DONE:   if (out_free) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		bin_ready    = (state_q == ST_IDLE);
		div_start    = state_q inside {ST_DIV_B, ST_DIV_S, ST_DIV_L};
		div_dividend = {p_q[25:0], 6'd0};
		div_divisor  = avg_q;
		case (state_q)
			ST_DIV_S: div_dividend = {p_inc[23:0], 8'd0};
			ST_DIV_L: begin
				div_dividend = p_led;
				div_divisor  = s_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			bin_counter_q <= '0;
			band_total_q  <= '0;
			frame_max_q   <= '0;
			avg_q         <= AVG_RESET;
			pend_last_q   <= 1'b0;
			band_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_DONE && out_free) begin
				band_valid_q <= 1'b1;
			end else if (band_ready) begin
				band_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (take) begin
						if (bin.frame_end || close) begin
							band_total_q <= '0;
						end else if (in_range) begin
							band_total_q <= total_new;
						end
						pend_last_q <= bin.frame_end;
						if (bin.frame_end) begin
							bin_counter_q <= '0;
							if (!close) begin
								avg_q       <= avg_new;
								frame_max_q <= '0;
							end
						end else if (bin_counter_q < COUNTER_TOP) begin
							bin_counter_q <= bin_counter_q + 10'd1;
						end
					end
				end
				ST_DIV_B: begin
					if (p_q > frame_max_q) begin
						frame_max_q <= p_q;
					end
				end
				ST_DONE: begin
					if (out_free && pend_last_q) begin
						avg_q       <= avg_new;
						frame_max_q <= '0;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && take && close) begin
			work_total_q <= total_new;
			found_q      <= found;
			first_q      <= first;
		end
		if (state_q == ST_SQUARE) begin
			p_q <= work_total_q * work_total_q;
		end
		if (state_q == ST_WAIT_B && div_stat.done) begin
			bright_q <= div_quo;
		end
		if (state_q == ST_WAIT_S && div_stat.done) begin
			s_q <= (div_quo == '0) ? 32'd1 : div_quo;
		end
		if (state_q == ST_WAIT_L && div_stat.done) begin
			lit_q <= (div_quo > 32'(LED_COUNT)) ? 8'(LED_COUNT) : div_quo[7:0];
		end
		if (state_q == ST_DONE && out_free) begin
			band_q.band_number <= found_q;
			band_q.first_led   <= first_q;
			band_q.lit_count   <= lit_q;
			band_q.rgb_colour  <= BAND_COLOURS[found_q];
			band_q.brightness  <= bright_q;
		end
	end

	assign band_valid = band_valid_q;
	assign band       = band_q;

	a_ready_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		bin_ready |-> !div_stat.busy)
		else $error("input taken while divider busy");

	a_avg_floor: assert property (@(posedge clk) disable iff (!arst_n)
		avg_q >= AVG_FLOOR)
		else $error("average peak below floor");

	a_lit_sat: assert property (@(posedge clk) disable iff (!arst_n)
		band_valid |-> band.lit_count <= 8'(LED_COUNT))
		else $error("lit count above LED count");

	a_band_range: assert property (@(posedge clk) disable iff (!arst_n)
		band_valid |-> band.band_number < 4'(BAND_COUNT))
		else $error("band number out of range");

endmodule
